### hdl/fit_pkg.sv
// shared types and constants of the flight interval timer
`timescale 1ns / 1ps

package fit_pkg;

	// default number of entries in each interval history store
	localparam int HISTORY_DEPTH_DEF = 64;

	// configuration register indexes
	localparam logic [1:0] CFG_PERIOD   = 2'd0;
	localparam logic [1:0] CFG_STEP     = 2'd1;
	localparam logic [1:0] CFG_PAGE_LEN = 2'd2;

	// reset value of the page length register
	localparam logic [3:0] PAGE_LEN_RST = 4'd5;

	// kind of interval recorded by one transaction
	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_FLIGHT = 2'd1,
		KIND_GAP    = 2'd2
	} kind_t;

	// configuration register file contents
	typedef struct packed {
		logic [31:0]       period;
		logic signed [1:0] step;
		logic [3:0]        page_len;
	} cfg_t;

	// history store controls for one transaction
	typedef struct packed {
		logic rd_en;
		logic fl_we;
		logic gp_we;
		logic rd_zero;
		logic rd_bypass;
	} hist_ctl_t;

endpackage

### hdl/fit_cfg_regs.sv
// configuration register file of the flight interval timer
`timescale 1ns / 1ps

module fit_cfg_regs
	import fit_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period   <= '0;
			cfg_q.step     <= '0;
			cfg_q.page_len <= PAGE_LEN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PERIOD:   cfg_q.period   <= cfg_data;
				CFG_STEP:     cfg_q.step     <= cfg_data[1:0];
				CFG_PAGE_LEN: cfg_q.page_len <= cfg_data[3:0];
				default:      ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/fit_history.sv
// flight and gap interval history stores with registered read-back
`timescale 1ns / 1ps

module fit_history
	import fit_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	localparam int IW = $clog2(HISTORY_DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  hist_ctl_t     ctl,
	input  logic [IW-1:0] fl_waddr,
	input  logic [IW-1:0] gp_waddr,
	input  logic [31:0]   wdata,
	input  logic [IW-1:0] raddr,
	output logic [31:0]   read_data
);

	logic [31:0] flight_mem [HISTORY_DEPTH];
	logic [31:0] gap_mem [HISTORY_DEPTH];
	logic [31:0] mem_rd_q;
	logic [31:0] byp_data_q;
	logic        zero_q;
	logic        byp_q;

	// store writes
	always_ff @(posedge clk) begin
		if (ctl.fl_we) begin
			flight_mem[fl_waddr] <= wdata;
		end
		if (ctl.gp_we) begin
			gap_mem[gp_waddr] <= wdata;
		end
	end

	// flight store read, old contents at a same-cycle write
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			mem_rd_q   <= flight_mem[raddr];
			byp_data_q <= wdata;
		end
	end

	// read selection flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_q <= 1'b1;
			byp_q  <= 1'b0;
		end else if (ctl.rd_en) begin
			zero_q <= ctl.rd_zero;
			byp_q  <= ctl.rd_bypass;
		end
	end

	// entries beyond the count read as zero, a fresh write is forwarded
	assign read_data = zero_q ? 32'd0 : (byp_q ? byp_data_q : mem_rd_q);

endmodule

### hdl/fit_pass.sv
// timer state and the per-transaction update of one loop pass
`timescale 1ns / 1ps

module fit_pass
	import fit_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	localparam int IW = $clog2(HISTORY_DEPTH),
	localparam int CW = $clog2(HISTORY_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  cfg_t          cfg,
	input  logic [31:0]   raw_time_ms,
	input  logic          press_timer,
	input  logic          press_aux,
	input  logic [IW-1:0] read_index,
	output logic [31:0]   corrected_time,
	output logic          running,
	output logic [CW-1:0] flight_total,
	output logic [CW-1:0] gap_total,
	output logic [CW-1:0] page_start,
	output logic [31:0]   round_begin,
	output logic [31:0]   recorded_ms,
	output logic [1:0]    recorded_kind,
	output logic          store_full,
	output hist_ctl_t     hist_ctl,
	output logic [IW-1:0] fl_waddr,
	output logic [IW-1:0] gp_waddr,
	output logic [31:0]   wdata,
	output logic [IW-1:0] raddr
);

	localparam int PW = (CW > 4) ? CW : 4;
	localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);

	// state
	logic [31:0]   drift_q, last_corr_q, last_press_q, round_begin_q;
	logic          running_q;
	logic [CW-1:0] fcount_q, gcount_q, page_q;
	// result payload
	logic [31:0]   now_q, rec_ms_q;
	kind_t         kind_q;
	logic          full_q;

	// next values
	logic [31:0]   now, span, drift_n, last_corr_n, round_n, rec_ms_n;
	logic          running_n, full_n, fl_we, gp_we;
	logic [CW-1:0] fcount_n, gcount_n, page_n;
	logic [PW-1:0] page_ext, plen_ext;
	kind_t         kind_n;

	assign now  = raw_time_ms + drift_q;
	assign span = now - last_press_q;

	// drift correction
	always_comb begin
		drift_n     = drift_q;
		last_corr_n = last_corr_q;
		if ((cfg.period != 32'd0) && ((now - last_corr_q) > cfg.period)) begin
			drift_n     = drift_q + {{30{cfg.step[1]}}, cfg.step};
			last_corr_n = now;
		end
	end

	// timer and aux button handling
	always_comb begin
		running_n = running_q;
		fcount_n  = fcount_q;
		gcount_n  = gcount_q;
		page_n    = page_q;
		round_n   = round_begin_q;
		rec_ms_n  = 32'd0;
		kind_n    = KIND_NONE;
		full_n    = 1'b0;
		fl_we     = 1'b0;
		gp_we     = 1'b0;
		page_ext  = '0;
		plen_ext  = '0;
		if (press_timer) begin
			if (!running_q) begin
				running_n = 1'b1;
				if (fcount_q != '0) begin
					if (gcount_q < DEPTH_C) begin
						gp_we    = 1'b1;
						gcount_n = gcount_q + 1'b1;
						rec_ms_n = span;
						kind_n   = KIND_GAP;
					end else begin
						full_n = 1'b1;
					end
				end
				if (round_begin_q == 32'd0) begin
					round_n = now;
				end
			end else begin
				running_n = 1'b0;
				if (fcount_q < DEPTH_C) begin
					fl_we    = 1'b1;
					fcount_n = fcount_q + 1'b1;
					if (page_q == fcount_q) begin
						page_n = fcount_q + 1'b1;
					end
					rec_ms_n = span;
					kind_n   = KIND_FLIGHT;
				end else begin
					full_n = 1'b1;
				end
			end
		end
		// aux button sees the state left by the timer button
		if (press_aux) begin
			if (!running_n && (round_n == 32'd0)) begin
				round_n = now;
			end else if (fcount_n > CW'(1)) begin
				page_ext = PW'(page_n);
				plen_ext = PW'(cfg.page_len);
				if (plen_ext > page_ext) begin
					page_n = fcount_n;
				end else begin
					page_n = CW'(page_ext - plen_ext);
				end
			end
		end
	end

	// state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drift_q       <= '0;
			last_corr_q   <= '0;
			last_press_q  <= '0;
			round_begin_q <= '0;
			running_q     <= 1'b0;
			fcount_q      <= '0;
			gcount_q      <= '0;
			page_q        <= '0;
		end else if (adv) begin
			drift_q       <= drift_n;
			last_corr_q   <= last_corr_n;
			round_begin_q <= round_n;
			running_q     <= running_n;
			fcount_q      <= fcount_n;
			gcount_q      <= gcount_n;
			page_q        <= page_n;
			if (press_timer) begin
				last_press_q <= now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			now_q    <= now;
			rec_ms_q <= rec_ms_n;
			kind_q   <= kind_n;
			full_q   <= full_n;
		end
	end

	// history store requests
	always_comb begin
		hist_ctl.rd_en     = adv;
		hist_ctl.fl_we     = adv && fl_we;
		hist_ctl.gp_we     = adv && gp_we;
		hist_ctl.rd_zero   = !(CW'(read_index) < fcount_n);
		hist_ctl.rd_bypass = fl_we && (CW'(read_index) == fcount_q);
	end

	assign fl_waddr = fcount_q[IW-1:0];
	assign gp_waddr = gcount_q[IW-1:0];
	assign wdata    = span;
	assign raddr    = read_index;

	assign corrected_time = now_q;
	assign running        = running_q;
	assign flight_total   = fcount_q;
	assign gap_total      = gcount_q;
	assign page_start     = page_q;
	assign round_begin    = round_begin_q;
	assign recorded_ms    = rec_ms_q;
	assign recorded_kind  = kind_q;
	assign store_full     = full_q;

endmodule

### hdl/flight_interval_timer_core.sv
// top level of the flight interval timer: input stage, config registers, pass logic, history
`timescale 1ns / 1ps

// channel   | handshake          | payload
// ----------+--------------------+------------------------------------------
// input     | in_valid, in_stall | raw_time_ms, press_timer, press_aux,
//           |                    | read_index
// result    | out_valid,         | corrected_time, running, flight_total,
//           | out_stall          | gap_total, page_start, round_begin,
//           |                    | recorded_ms, recorded_kind, store_full,
//           |                    | read_flight_ms
// config    | cfg_we             | cfg_index, cfg_data
//
// one transaction per cycle sustained while the result is not stalled, via
// an input register, then the pass update into the result register and store
// the history stores need no clearing pass, entries past the count read as 0
// reset clears the timer state and the stage valid bits, not the stores
// a stalled result holds, and the input stage keeps accepting while the
// result register is free or being taken

module flight_interval_timer_core
	import fit_pkg::*;
#(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
	localparam int IW = $clog2(HISTORY_DEPTH),
	localparam int CW = $clog2(HISTORY_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [31:0]   raw_time_ms,
	input  logic          press_timer,
	input  logic          press_aux,
	input  logic [IW-1:0] read_index,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [31:0]   corrected_time,
	output logic          running,
	output logic [CW-1:0] flight_total,
	output logic [CW-1:0] gap_total,
	output logic [CW-1:0] page_start,
	output logic [31:0]   round_begin,
	output logic [31:0]   recorded_ms,
	output logic [1:0]    recorded_kind,
	output logic          store_full,
	output logic [31:0]   read_flight_ms,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	cfg_t          cfg;
	hist_ctl_t     hist_ctl;
	logic [IW-1:0] fl_waddr, gp_waddr, raddr;
	logic [31:0]   wdata;

	logic          vld_s1;
	logic [31:0]   raw_s1;
	logic          ptimer_s1, paux_s1;
	logic [IW-1:0] ridx_s1;
	logic          out_valid_q;
	logic          adv, accept;

	// stage handshake
	assign adv      = vld_s1 && (!out_valid_q || !out_stall);
	assign in_stall = vld_s1 && !adv;
	assign accept   = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			raw_s1    <= raw_time_ms;
			ptimer_s1 <= press_timer;
			paux_s1   <= press_aux;
			ridx_s1   <= read_index;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	fit_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fit_pass #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_pass (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.cfg            (cfg),
		.raw_time_ms    (raw_s1),
		.press_timer    (ptimer_s1),
		.press_aux      (paux_s1),
		.read_index     (ridx_s1),
		.corrected_time (corrected_time),
		.running        (running),
		.flight_total   (flight_total),
		.gap_total      (gap_total),
		.page_start     (page_start),
		.round_begin    (round_begin),
		.recorded_ms    (recorded_ms),
		.recorded_kind  (recorded_kind),
		.store_full     (store_full),
		.hist_ctl       (hist_ctl),
		.fl_waddr       (fl_waddr),
		.gp_waddr       (gp_waddr),
		.wdata          (wdata),
		.raddr          (raddr)
	);

	fit_history #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_history (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (hist_ctl),
		.fl_waddr  (fl_waddr),
		.gp_waddr  (gp_waddr),
		.wdata     (wdata),
		.raddr     (raddr),
		.read_data (read_flight_ms)
	);

	// a recorded flight ends timing, a recorded gap starts it
	a_flight_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (recorded_kind == KIND_FLIGHT)) |-> !running)
		else $error("flight recorded while still running");

	a_gap_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (recorded_kind == KIND_GAP)) |-> running)
		else $error("gap recorded while not running");

	// a dropped interval records nothing
	a_full_none: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && store_full) |-> (recorded_kind == KIND_NONE))
		else $error("interval both dropped and recorded");

	// counts stay within the store and gaps never outnumber flights
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(flight_total <= CW'(HISTORY_DEPTH)) && (gap_total <= flight_total))
		else $error("history counts out of range");

endmodule

### bench/tb_flight_interval_timer_core.sv
// self-checking testbench of the flight interval timer core
`timescale 1ns / 1ps

module tb_flight_interval_timer_core;
	import fit_pkg::*;

	localparam int HIST = HISTORY_DEPTH_DEF;

	// one loop pass offered to the block
	typedef struct {
		logic [31:0] raw;
		logic        timer;
		logic        aux;
		logic [5:0]  idx;
	} timer_pass_t;

	// what the block should report for one pass
	typedef struct {
		logic [31:0] now;
		logic        run;
		logic [6:0]  n_fl;
		logic [6:0]  n_gp;
		logic [6:0]  page;
		logic [31:0] round;
		logic [31:0] rec;
		kind_t       kind;
		logic        full;
		logic [31:0] rd;
	} timer_report_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] raw_time_ms = '0;
	logic        press_timer = 1'b0;
	logic        press_aux = 1'b0;
	logic [5:0]  read_index = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] corrected_time;
	logic        running;
	logic [6:0]  flight_total;
	logic [6:0]  gap_total;
	logic [6:0]  page_start;
	logic [31:0] round_begin;
	logic [31:0] recorded_ms;
	logic [1:0]  recorded_kind;
	logic        store_full;
	logic [31:0] read_flight_ms;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_PERIOD;
	logic [31:0] cfg_data = '0;

	// queues between stimulus, driver and checker
	timer_pass_t   pending_passes[$];
	timer_report_t expected_reports[$];
	int            mismatches = 0;
	logic          in_taken = 1'b0;
	bit            quiet = 1'b0;
	int            holds_asked = 0;
	int            holds_granted = 0;
	int            hold_left = 0;
	logic [31:0]   clock_ms = '0;

	// predicted register file
	logic [31:0] cfg_period = '0;
	logic [1:0]  cfg_step = '0;
	logic [3:0]  cfg_page_len = PAGE_LEN_RST;

	// predicted timer state
	logic [31:0] cur_drift = '0;
	logic [31:0] last_fix = '0;
	logic        flying = 1'b0;
	logic [31:0] last_press_ms = '0;
	logic [31:0] round_ms = '0;
	logic [6:0]  n_flight = '0;
	logic [6:0]  n_gap = '0;
	logic [7:0]  page_idx = '0;
	logic [31:0] flight_log [0:HIST-1];

	flight_interval_timer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.raw_time_ms(raw_time_ms),
		.press_timer(press_timer),
		.press_aux(press_aux),
		.read_index(read_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.corrected_time(corrected_time),
		.running(running),
		.flight_total(flight_total),
		.gap_total(gap_total),
		.page_start(page_start),
		.round_begin(round_begin),
		.recorded_ms(recorded_ms),
		.recorded_kind(recorded_kind),
		.store_full(store_full),
		.read_flight_ms(read_flight_ms),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// advance the timer state by one loop pass and report the outcome
	task automatic advance_timer(input timer_pass_t p, output timer_report_t r);
		logic [31:0] now;
		logic [31:0] span;
		now = p.raw + cur_drift;
		r.rec = '0;
		r.kind = KIND_NONE;
		r.full = 1'b0;
		// drift correction uses the time from before the step
		if (cfg_period != 0 && (now - last_fix) > cfg_period) begin
			cur_drift = cur_drift + {{30{cfg_step[1]}}, cfg_step};
			last_fix = now;
		end
		if (p.timer) begin
			span = now - last_press_ms;
			if (!flying) begin
				flying = 1'b1;
				if (n_flight > 0) begin
					if (n_gap < 7'(HIST)) begin
						n_gap = n_gap + 7'd1;
						r.rec = span;
						r.kind = KIND_GAP;
					end else begin
						r.full = 1'b1;
					end
				end
				if (round_ms == 0)
					round_ms = now;
			end else begin
				flying = 1'b0;
				if (n_flight < 7'(HIST)) begin
					flight_log[n_flight] = span;
					if (page_idx == {1'b0, n_flight})
						page_idx = {1'b0, n_flight} + 8'd1;
					n_flight = n_flight + 7'd1;
					r.rec = span;
					r.kind = KIND_FLIGHT;
				end else begin
					r.full = 1'b1;
				end
			end
			last_press_ms = now;
		end
		// aux starts the round clock or pages back
		if (p.aux) begin
			if (!flying && round_ms == 0) begin
				round_ms = now;
			end else if (n_flight > 1) begin
				if ({4'b0, cfg_page_len} > page_idx)
					page_idx = {1'b0, n_flight};
				else
					page_idx = page_idx - {4'b0, cfg_page_len};
			end
		end
		r.rd = (p.idx < n_flight) ? flight_log[p.idx] : '0;
		r.now = now;
		r.run = flying;
		r.n_fl = n_flight;
		r.n_gp = n_gap;
		r.page = page_idx[6:0];
		r.round = round_ms;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// monitor: check result transactions, predict accepted input transactions
	always @(posedge clk) begin
		timer_report_t want;
		timer_report_t pred;
		timer_pass_t   seen;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					$error("result transaction with no expected result");
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					check_field("corrected_time", want.now, corrected_time);
					check_field("running", want.run, running);
					check_field("flight_total", want.n_fl, flight_total);
					check_field("gap_total", want.n_gp, gap_total);
					check_field("page_start", want.page, page_start);
					check_field("round_begin", want.round, round_begin);
					check_field("recorded_ms", want.rec, recorded_ms);
					check_field("recorded_kind", want.kind, recorded_kind);
					check_field("store_full", want.full, store_full);
					check_field("read_flight_ms", want.rd, read_flight_ms);
				end
			end
			if (in_valid && !in_stall) begin
				seen.raw = raw_time_ms;
				seen.timer = press_timer;
				seen.aux = press_aux;
				seen.idx = read_index;
				advance_timer(seen, pred);
				expected_reports.push_back(pred);
			end
			in_taken <= in_valid && !in_stall;
		end else begin
			in_taken <= 1'b0;
		end
	end

	// driver: offer the next pending pass once the current one is taken
	always @(negedge clk) begin
		timer_pass_t nxt;
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_passes.size() != 0 && (quiet || $urandom_range(0, 99) >= 10)) begin
				nxt = pending_passes.pop_front();
				in_valid <= 1'b1;
				raw_time_ms <= nxt.raw;
				press_timer <= nxt.timer;
				press_aux <= nxt.aux;
				read_index <= nxt.idx;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_granted != holds_asked) begin
			holds_granted <= holds_granted + 1;
			hold_left <= 80;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !quiet && ($urandom_range(0, 99) < 10);
		end
	end

	task automatic queue_pass(input logic [31:0] raw, input logic timer, input logic aux,
		input logic [5:0] idx);
		timer_pass_t p;
		p.raw = raw;
		p.timer = timer;
		p.aux = aux;
		p.idx = idx;
		pending_passes.push_back(p);
	endtask

	// mostly a rising clock, with jumps and wraps now and then
	task automatic queue_random(input int count);
		int roll;
		int i;
		for (i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 5)
				clock_ms = $urandom();
			else if (roll < 8)
				clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
			else
				clock_ms = clock_ms + $urandom_range(0, 1500);
			queue_pass(clock_ms, $urandom_range(0, 99) < 30, $urandom_range(0, 99) < 15,
				($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, 63)) :
				6'($urandom_range(0, 7)));
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PERIOD: cfg_period = val;
			CFG_STEP: cfg_step = val[1:0];
			CFG_PAGE_LEN: cfg_page_len = val[3:0];
			default: ;
		endcase
	endtask

	// wait until every pass is taken and every report has come back
	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_passes.size() != 0 || in_valid || expected_reports.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_setting(input logic [31:0] period, input logic [1:0] step,
		input logic [3:0] plen, input int count, input bit no_idle, input bit long_hold);
		write_reg(CFG_PERIOD, period);
		write_reg(CFG_STEP, {30'b0, step});
		write_reg(CFG_PAGE_LEN, {28'b0, plen});
		quiet = no_idle;
		if (long_hold)
			holds_asked++;
		queue_random(count);
		wait_drained();
	endtask

	// stimulus sequence
	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// round start at time zero, then flights and gaps across the wrap
		queue_pass(32'h0000_0000, 1'b0, 1'b1, 6'd63);
		queue_pass(32'h0000_0000, 1'b1, 1'b0, 6'd0);
		queue_pass(32'hFFFF_FFFF, 1'b1, 1'b0, 6'd0);
		queue_pass(32'h0000_0005, 1'b0, 1'b1, 6'd0);
		queue_pass(32'h0000_0003, 1'b1, 1'b0, 6'd1);
		queue_pass(32'd1000, 1'b1, 1'b1, 6'd1);
		queue_pass(32'd1100, 1'b1, 1'b0, 6'd0);
		queue_pass(32'd1300, 1'b1, 1'b1, 6'd2);
		queue_pass(32'd1400, 1'b1, 1'b1, 6'd0);
		queue_pass(32'd1500, 1'b1, 1'b0, 6'd3);
		queue_pass(32'd1600, 1'b1, 1'b0, 6'd0);
		queue_pass(32'd1700, 1'b1, 1'b0, 6'd63);
		queue_pass(32'd1800, 1'b0, 1'b1, 6'd4);
		queue_pass(32'd1900, 1'b0, 1'b1, 6'd4);
		queue_pass(32'd2000, 1'b0, 1'b1, 6'd2);
		queue_pass(32'd2100, 1'b0, 1'b0, 6'd0);
		queue_pass(32'h8000_0000, 1'b0, 1'b0, 6'h2A);
		queue_pass(32'h7FFF_FFFF, 1'b0, 1'b0, 6'h15);
		clock_ms = 32'd2500;
		queue_random(130);
		wait_drained();

		// sweep settings, extremes included
		run_setting(32'd100, 2'b01, 4'd1, 150, 1'b1, 1'b0);
		run_setting(32'd1, 2'b11, 4'd15, 150, 1'b0, 1'b1);
		run_setting(32'hFFFF_FFFF, 2'b10, 4'd0, 100, 1'b0, 1'b0);
		run_setting(32'd0, 2'b01, PAGE_LEN_RST, 150, 1'b0, 1'b0);
		run_setting(32'd500, 2'b11, 4'd3, 150, 1'b0, 1'b1);

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog
	initial begin
		#400000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
